### rtl/lds_pkg.sv
// Shared types and constants of the dusk lamp sequencer.
package lds_pkg;

    // Field widths.
    localparam int unsigned StepsW  = 10;
    localparam int unsigned TicksW  = 24;
    localparam int unsigned LuxW    = 16;
    localparam int unsigned ChgW    = 2;
    localparam int unsigned CodeW   = 12;
    localparam int unsigned CfgAddrW = 2;
    localparam int unsigned CfgDataW = 24;

    // Stream beat widths, padded to whole bytes.
    localparam int unsigned InDataW  = 24;
    localparam int unsigned OutDataW = 16;

    // Step-to-code scaling: code = floor(steps * 312 / 50) as (steps * DacMul) >> DacShift.
    localparam int unsigned DacShift = 16;
    localparam int unsigned DacMulW  = 19;
    localparam logic [DacMulW-1:0] DacMul = 19'd408945;
    localparam int unsigned DacProdW = StepsW + DacMulW;
    localparam logic [CodeW-1:0] DacMax = '1;

    localparam logic [TicksW-1:0] TicksMax = '1;

    // Register reset values.
    localparam logic [StepsW-1:0] TargetStepsRst = 10'd600;
    localparam logic [TicksW-1:0] OnTimeTicksRst = 24'd1800000;
    localparam logic [LuxW-1:0]   DarkLuxRst     = 16'd100;
    localparam logic [LuxW-1:0]   DayLuxRst      = 16'd500;

    // Charger status code for an unplugged charger.
    localparam logic [ChgW-1:0] ChgNone = 2'd0;

    // Configuration register indexes.
    typedef enum logic [CfgAddrW-1:0] {
        CFG_TARGET_STEPS  = 2'd0,
        CFG_ON_TIME_TICKS = 2'd1,
        CFG_DARK_LUX      = 2'd2,
        CFG_DAY_LUX       = 2'd3
    } t_cfg_addr;

    // Lamp modes.
    typedef enum logic [1:0] {
        MODE_ON        = 2'd0,
        MODE_TURN_OFF  = 2'd1,
        MODE_OFF_NIGHT = 2'd2,
        MODE_OFF_DAY   = 2'd3
    } t_mode;

    // Current register settings.
    typedef struct packed {
        logic [StepsW-1:0] target_steps;
        logic [TicksW-1:0] on_time_ticks;
        logic [LuxW-1:0]   dark_lux;
        logic [LuxW-1:0]   day_lux;
    } t_cfg;

    // Outcome of one tick as seen after the state update.
    typedef struct packed {
        logic [StepsW-1:0] steps;
        logic              wrote;
        t_mode             mode;
    } t_tick_res;

endpackage

### rtl/lds_cfg_regs.sv
// Configuration register file of the dusk lamp sequencer.
module lds_cfg_regs
    import lds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_wdata,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;

    // Each write lands in the register its index selects.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_steps  <= TargetStepsRst;
            r_cfg.on_time_ticks <= OnTimeTicksRst;
            r_cfg.dark_lux      <= DarkLuxRst;
            r_cfg.day_lux       <= DayLuxRst;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_TARGET_STEPS:  r_cfg.target_steps  <= i_cfg_wdata[StepsW-1:0];
                CFG_ON_TIME_TICKS: r_cfg.on_time_ticks <= i_cfg_wdata[TicksW-1:0];
                CFG_DARK_LUX:      r_cfg.dark_lux      <= i_cfg_wdata[LuxW-1:0];
                CFG_DAY_LUX:       r_cfg.day_lux       <= i_cfg_wdata[LuxW-1:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/lds_tick_fsm.sv
// Mode machine, voltage ramp and on-time counter, advanced once per tick.
module lds_tick_fsm
    import lds_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tick,
    input  logic [LuxW-1:0] i_lux,
    input  logic [ChgW-1:0] i_chg,
    input  t_cfg            i_cfg,
    output t_tick_res       o_res
);

    t_mode             r_mode;
    logic [StepsW-1:0] r_steps;
    logic [TicksW-1:0] r_ticks;
    logic [ChgW-1:0]   r_prev_chg;

    t_mode             n_mode;
    logic [StepsW-1:0] n_steps;
    logic [TicksW-1:0] n_ticks;
    logic              n_wrote;
    t_mode             mode_base;
    logic [TicksW-1:0] ticks_inc;
    logic              is_day;
    logic              plug_in;
    logic              unplug;

    assign ticks_inc = (r_ticks == TicksMax) ? r_ticks : r_ticks + 1'b1;
    assign is_day    = i_lux > i_cfg.day_lux;
    assign plug_in   = (i_chg != ChgNone) && (r_prev_chg == ChgNone);
    assign unplug    = (i_chg == ChgNone) && (r_prev_chg != ChgNone);

    // Next mode: the per-mode transition, then charger edges override it.
    always_comb begin
        mode_base = r_mode;
        unique case (r_mode)
            MODE_ON: begin
                if ((ticks_inc >= i_cfg.on_time_ticks) || is_day) begin
                    mode_base = MODE_TURN_OFF;
                end
            end
            MODE_TURN_OFF: begin
                if (r_steps == '0) begin
                    mode_base = MODE_OFF_NIGHT;
                end
            end
            MODE_OFF_NIGHT: begin
                if (is_day) begin
                    mode_base = MODE_OFF_DAY;
                end
            end
            MODE_OFF_DAY: begin
                if (i_lux < i_cfg.dark_lux) begin
                    mode_base = MODE_ON;
                end
            end
            default: mode_base = r_mode;
        endcase
        priority if (unplug) begin
            n_mode = MODE_OFF_DAY;
        end else if (plug_in) begin
            n_mode = MODE_TURN_OFF;
        end else begin
            n_mode = mode_base;
        end
    end

    // Ramp and counter updates for the current mode.
    always_comb begin
        n_steps = r_steps;
        n_ticks = r_ticks;
        n_wrote = 1'b0;
        unique case (r_mode)
            MODE_ON: begin
                n_ticks = ticks_inc;
                if (r_steps < i_cfg.target_steps) begin
                    n_steps = r_steps + 1'b1;
                    n_wrote = 1'b1;
                end
            end
            MODE_TURN_OFF: begin
                if (r_steps != '0) begin
                    n_steps = r_steps - 1'b1;
                    n_wrote = 1'b1;
                end
            end
            MODE_OFF_NIGHT: begin
                n_steps = r_steps;
            end
            MODE_OFF_DAY: begin
                if (i_lux < i_cfg.dark_lux) begin
                    n_ticks = '0;
                end
            end
            default: n_steps = r_steps;
        endcase
    end

    // State advances only on a tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_OFF_DAY;
            r_steps    <= '0;
            r_ticks    <= '0;
            r_prev_chg <= ChgNone;
        end else if (i_tick) begin
            r_mode     <= n_mode;
            r_steps    <= n_steps;
            r_ticks    <= n_ticks;
            r_prev_chg <= i_chg;
        end
    end

    assign o_res.steps = n_steps;
    assign o_res.wrote = n_wrote;
    assign o_res.mode  = n_mode;

endmodule

### rtl/lds_dac_scale.sv
// Converts a voltage step count to a saturated DAC code.
module lds_dac_scale
    import lds_pkg::*;
(
    input  logic [StepsW-1:0] i_steps,
    output logic [CodeW-1:0]  o_code
);

    logic [DacProdW-1:0]          prod;
    logic [DacProdW-DacShift-1:0] quot;

    // Multiply by the scaled reciprocal; exact floor for every 10-bit count.
    assign prod = DacProdW'(i_steps) * DacProdW'(DacMul);
    assign quot = prod[DacProdW-1:DacShift];

    // Clamp to the DAC's full scale.
    assign o_code = (quot > (DacProdW-DacShift)'(DacMax)) ? DacMax : quot[CodeW-1:0];

endmodule

### rtl/lamp_dusk_sequencer.sv
// Top level of the dusk lamp sequencer: stream ports, input and result registers.
//
// Each input beat is one 10 ms tick carrying the averaged ambient brightness
// and the charger status. For every tick the block returns one output beat
// with the lamp DAC code, a flag telling whether the DAC is written this
// tick, and the lamp mode after the tick.
// Configuration goes through a plain write port (enable, index, data); the
// registers take effect for the next tick and should be written while idle.
// Path: a tick accepted into the input register updates the lamp state and
// lands in the result register once the result slot is free, and is then
// offered on the output.
// Throughput: one tick per cycle while results are taken; mode update, ramp
// step and the single step-to-code multiply all fit between input and result registers.
// Stall: while the receiver holds m_axis_tready low, the result and the
// lamp state are frozen; an empty input register still takes one more tick,
// after which s_axis_tready drops until the result beat is taken.
// Reset (synchronous, active low) empties both registers, sets the lamp off
// by day with zero voltage and zero on-time, and loads the default settings.
module lamp_dusk_sequencer
    import lds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input stream; tdata from bit 0: ambient_lux[15:0], charge_status[17:16], zero pad.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,
    // Result stream; tdata from bit 0: dac_code[11:0], dac_write[12], lamp_mode[14:13], pad.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata,
    // Configuration write port.
    input  logic                i_cfg_wr_en,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_wdata
);

    t_cfg             cfg;
    t_tick_res        tick_res;
    logic [CodeW-1:0] next_code;
    logic             out_free;
    logic             advance;

    logic             r_in_valid;
    logic [LuxW-1:0]  r_lux;
    logic [ChgW-1:0]  r_chg;
    logic             r_out_valid;
    logic [CodeW-1:0] r_code;
    logic             r_wrote;
    t_mode            r_mode_out;

    // Handshake: the result slot frees when taken; input moves on when it advances.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    lds_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    lds_tick_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (advance),
        .i_lux   (r_lux),
        .i_chg   (r_chg),
        .i_cfg   (cfg),
        .o_res   (tick_res)
    );

    lds_dac_scale u_dac (
        .i_steps (tick_res.steps),
        .o_code  (next_code)
    );

    // Input register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_lux <= s_axis_tdata[LuxW-1:0];
            r_chg <= s_axis_tdata[LuxW+ChgW-1:LuxW];
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_code     <= next_code;
            r_wrote    <= tick_res.wrote;
            r_mode_out <= tick_res.mode;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_mode_out, r_wrote, r_code};

endmodule

### rtl/lds_checker.sv
// Port-level checks of the dusk lamp sequencer and their binding.
module lds_stream_props
    import lds_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OutDataW-1:0] m_axis_tdata
);

    logic [CodeW-1:0] code;
    logic             wrote;
    logic [1:0]       mode;

    assign code  = m_axis_tdata[CodeW-1:0];
    assign wrote = m_axis_tdata[CodeW];
    assign mode  = m_axis_tdata[CodeW+2:CodeW+1];

    // A result beat stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // A stalled result keeps its contents.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Off at night is reached only at zero voltage, so nothing is written there.
    a_night_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (mode == MODE_OFF_NIGHT) |-> (code == '0) && !wrote)
        else $error("off at night with voltage or DAC write");

    // A write while on is a step up, so the code cannot be zero.
    a_ramp_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && wrote && (mode == MODE_ON) |-> (code != '0))
        else $error("ramp-up write with zero code");

    // With the result slot empty the input side must be ready.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result slot");

endmodule

bind lamp_dusk_sequencer lds_stream_props u_lds_stream_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### bench/lds_checker.sv
// Checker for the dusk lamp sequencer: tracks ticks, predicts each result and compares it.
module lds_checker
    import lds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Tick stream as seen on the block's input side.
    input  logic                i_tick_valid,
    input  logic                i_tick_ready,
    input  logic [InDataW-1:0]  i_tick_data,
    // Result stream as seen on the block's output side.
    input  logic                i_res_valid,
    input  logic                i_res_ready,
    input  logic [OutDataW-1:0] i_res_data,
    // Configuration writes.
    input  logic                i_cfg_wr_en,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_wdata,
    output int                  o_pending,
    output int                  o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    // One result beat, field by field.
    typedef struct {
        logic [CodeW-1:0] code;
        logic             wrote;
        t_mode            mode;
    } t_lamp_beat;

    // Predicted lamp state and register settings.
    t_cfg              settings;
    t_mode             lamp_mode;
    logic [StepsW-1:0] lamp_level;
    logic [TicksW-1:0] lit_ticks;
    logic [ChgW-1:0]   last_charge;

    t_lamp_beat lamp_queue[$];
    int         fault_count;
    int         beats_seen;

    initial begin
        fault_count = 0;
        beats_seen  = 0;
    end

    // DAC code of a voltage level, floored and clipped to the converter range.
    function automatic logic [CodeW-1:0] dac_code_of(input logic [StepsW-1:0] level);
        int unsigned scaled;
        scaled = (int'(level) * 312) / 50;
        if (scaled > int'(DacMax)) begin
            return DacMax;
        end
        return scaled[CodeW-1:0];
    endfunction

    // Advances the lamp by one tick and returns the beat that the tick should produce.
    task automatic advance_lamp(input logic [LuxW-1:0] lux, input logic [ChgW-1:0] charge,
                                output t_lamp_beat beat);
        logic stepped;
        stepped = 1'b0;
        case (lamp_mode)
            MODE_ON: begin
                if (lamp_level < settings.target_steps) begin
                    lamp_level = lamp_level + 1'b1;
                    stepped    = 1'b1;
                end
                if (lit_ticks != TicksMax) begin
                    lit_ticks = lit_ticks + 1'b1;
                end
                if (lit_ticks >= settings.on_time_ticks || lux > settings.day_lux) begin
                    lamp_mode = MODE_TURN_OFF;
                end
            end
            MODE_TURN_OFF: begin
                if (lamp_level != '0) begin
                    lamp_level = lamp_level - 1'b1;
                    stepped    = 1'b1;
                end else begin
                    lamp_mode = MODE_OFF_NIGHT;
                end
            end
            MODE_OFF_NIGHT: begin
                if (lux > settings.day_lux) begin
                    lamp_mode = MODE_OFF_DAY;
                end
            end
            default: begin
                if (lux < settings.dark_lux) begin
                    lit_ticks = '0;
                    lamp_mode = MODE_ON;
                end
            end
        endcase

        // Charger edges override whatever the mode machine decided.
        if (charge != ChgNone && last_charge == ChgNone) begin
            lamp_mode = MODE_TURN_OFF;
        end
        if (charge == ChgNone && last_charge != ChgNone) begin
            lamp_mode = MODE_OFF_DAY;
        end
        last_charge = charge;

        beat.code  = dac_code_of(lamp_level);
        beat.wrote = stepped;
        beat.mode  = lamp_mode;
    endtask

    task automatic flag_fault(input string what);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    // All channels are sampled at the rising edge, before the edge's updates land.
    always @(posedge i_clk) begin : watch
        t_lamp_beat want;
        t_lamp_beat got;
        if (!i_rst_n) begin
            settings.target_steps  = TargetStepsRst;
            settings.on_time_ticks = OnTimeTicksRst;
            settings.dark_lux      = DarkLuxRst;
            settings.day_lux       = DayLuxRst;
            lamp_mode   = MODE_OFF_DAY;
            lamp_level  = '0;
            lit_ticks   = '0;
            last_charge = ChgNone;
            lamp_queue.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_addr'(i_cfg_addr))
                    CFG_TARGET_STEPS:  settings.target_steps  = i_cfg_wdata[StepsW-1:0];
                    CFG_ON_TIME_TICKS: settings.on_time_ticks = i_cfg_wdata[TicksW-1:0];
                    CFG_DARK_LUX:      settings.dark_lux      = i_cfg_wdata[LuxW-1:0];
                    default:           settings.day_lux       = i_cfg_wdata[LuxW-1:0];
                endcase
            end

            if (i_tick_valid && i_tick_ready) begin
                advance_lamp(i_tick_data[LuxW-1:0], i_tick_data[LuxW+ChgW-1:LuxW], want);
                lamp_queue.push_back(want);
            end

            if (i_res_valid && i_res_ready) begin
                beats_seen++;
                got.code  = i_res_data[CodeW-1:0];
                got.wrote = i_res_data[CodeW];
                got.mode  = t_mode'(i_res_data[CodeW+2:CodeW+1]);
                if (lamp_queue.size() == 0) begin
                    flag_fault($sformatf("result beat %0d arrived with no tick waiting for it",
                                         beats_seen));
                end else begin
                    want = lamp_queue.pop_front();
                    if (got.code !== want.code || got.wrote !== want.wrote ||
                        got.mode !== want.mode) begin
                        flag_fault($sformatf({"result beat %0d: expected code %0d write %0d ",
                                              "mode %0d, got code %0d write %0d mode %0d"},
                                             beats_seen, want.code, want.wrote, want.mode,
                                             got.code, got.wrote, got.mode));
                    end
                end
            end
        end
        o_pending <= lamp_queue.size();
        o_errors  <= fault_count;
    end

endmodule

### bench/lamp_dusk_sequencer_test.sv
// Top of the dusk lamp sequencer testbench: clock, reset, tick stimulus and the verdict.
module lamp_dusk_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lds_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                i_cfg_wr_en;
    logic [CfgAddrW-1:0] i_cfg_addr;
    logic [CfgDataW-1:0] i_cfg_wdata;

    int tally_pending;
    int tally_errors;
    int burst_left;
    bit squeeze_arm;

    lamp_dusk_sequencer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    lds_checker lamp_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_valid (s_axis_tvalid),
        .i_tick_ready (s_axis_tready),
        .i_tick_data  (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_pending    (tally_pending),
        .o_errors     (tally_errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offers one tick and returns right after the edge that accepts it.
    task automatic send_tick(input logic [LuxW-1:0] lux, input logic [ChgW-1:0] charge);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(InDataW-LuxW-ChgW){1'b0}}, charge, lux};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Sends a tick as part of a burst; a random gap follows each burst.
    task automatic paced_tick(input logic [LuxW-1:0] lux, input logic [ChgW-1:0] charge);
        send_tick(lux, charge);
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(1, 16);
        end
    endtask

    // Stops sending and waits until every tick has come back.
    task automatic drain_ticks();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tally_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes one register; the caller drops the write enable after the last one.
    task automatic write_reg(input t_cfg_addr index, input int unsigned value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= index;
        i_cfg_wdata <= value[CfgDataW-1:0];
        @(posedge i_clk);
    endtask

    // Tick brightness: under 65535 if calm, else mostly the sky region, some noise.
    function automatic logic [LuxW-1:0] pick_lux(input bit dark_sky, input bit calm,
                                                 input int unsigned dark, input int unsigned day);
        int unsigned roll;
        int unsigned lo;
        int unsigned hi;
        roll = $urandom_range(0, 9);
        lo   = (dark < day) ? dark : day;
        hi   = (dark < day) ? day : dark;
        if (calm) begin
            return LuxW'($urandom_range(0, 65534));
        end
        if (roll == 0) begin
            return LuxW'($urandom_range(0, 65535));
        end
        if (roll == 1) begin
            return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
        end
        if (dark_sky) begin
            return (dark == 0) ? 16'h0000 : LuxW'($urandom_range(0, dark - 1));
        end
        if (roll < 4) begin
            return LuxW'($urandom_range(lo, hi));
        end
        return (day >= 65535) ? 16'hFFFF : LuxW'($urandom_range(day + 1, 65535));
    endfunction

    // One night setting: load the registers while idle, then run random ticks.
    task automatic run_night(input int unsigned target, input int unsigned on_time,
                             input int unsigned dark, input int unsigned day,
                             input int unsigned count, input bit calm);
        bit              dark_sky;
        logic [ChgW-1:0] charge;
        int unsigned     n;
        drain_ticks();
        write_reg(CFG_TARGET_STEPS, target);
        write_reg(CFG_ON_TIME_TICKS, on_time);
        write_reg(CFG_DARK_LUX, dark);
        write_reg(CFG_DAY_LUX, day);
        i_cfg_wr_en <= 1'b0;
        // A calm night arms the long receiver hold-off while ticks keep coming.
        // It starts from off by day: a plug and unplug pair forces it.
        if (calm) begin
            squeeze_arm = 1'b1;
            send_tick(16'h0000, 2'd1);
            send_tick(16'h0000, ChgNone);
        end
        dark_sky = 1'b1;
        charge   = ChgNone;
        for (n = 0; n < count; n++) begin
            if (!calm && $urandom_range(0, 19) == 0) begin
                dark_sky = !dark_sky;
            end
            if (!calm && $urandom_range(0, 29) == 0) begin
                charge = ChgW'($urandom_range(0, 3));
            end
            paced_tick(pick_lux(dark_sky, calm, dark, day), charge);
        end
    endtask

    // Result side: stall patterns of random length, plus one long hold-off.
    initial begin : receiver
        int unsigned kind;
        int unsigned span;
        int unsigned held;
        bit          squeezed;
        squeezed = 1'b0;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            kind = $urandom_range(0, 3);
            span = $urandom_range(8, 40);
            repeat (span) begin
                case (kind)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge i_clk);
            end
            if (squeeze_arm && !squeezed) begin
                squeezed = 1'b1;
                m_axis_tready <= 1'b0;
                for (held = 0; held < 64; held++) @(posedge i_clk);
            end
        end
    end

    // Stimulus.
    initial begin
        squeeze_arm = 1'b0;
        burst_left  = 8;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_addr    <= CFG_TARGET_STEPS;
        i_cfg_wdata   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed ticks at the reset settings: ramp, thresholds and charger edges.
        send_tick(16'd0, 2'd0);        // dark: off by day goes on
        send_tick(16'd99, 2'd0);
        send_tick(16'd500, 2'd0);      // exactly at the day threshold stays on
        send_tick(16'd501, 2'd0);      // just above it starts turning off
        send_tick(16'hFFFF, 2'd0);
        send_tick(16'd0, 2'd0);
        send_tick(16'd0, 2'd0);
        send_tick(16'd0, 2'd0);        // at zero: no DAC write, goes off at night
        send_tick(16'd0, 2'd0);        // no DAC write, off at night
        send_tick(16'd500, 2'd0);
        send_tick(16'hFFFF, 2'd0);     // daylight: off by day
        send_tick(16'd100, 2'd0);      // exactly at the dark threshold stays off
        send_tick(16'd0, 2'd0);
        send_tick(16'd0, 2'd1);        // charger plugged in while lit
        send_tick(16'd0, 2'd2);
        send_tick(16'd0, 2'd0);        // unplugged while turning off
        send_tick(16'd0, 2'd3);        // dark and plugged in the same tick: turning off wins
        send_tick(16'd0, 2'd3);
        send_tick(16'd0, 2'd3);
        send_tick(16'hFFFF, 2'd3);
        send_tick(16'd0, 2'd3);        // lit while the charger stays in
        send_tick(16'd0, 2'd3);
        send_tick(16'd0, 2'd0);        // unplugged while lit keeps its level
        send_tick(16'd0, 2'd0);        // goes on again from the kept level

        // Random nights across register settings, extremes included.
        run_night(8, 40, 100, 500, 50, 1'b0);
        run_night(1, 1, 65535, 65535, 40, 1'b0);
        run_night(0, 0, 30000, 30000, 40, 1'b0);
        run_night(1023, 16777215, 65535, 65535, 330, 1'b1);
        run_night(656, 100, 200, 0, 40, 1'b0);
        run_night(600, 1800000, 100, 500, 30, 1'b0);

        drain_ticks();
        if (tally_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
